// ----- rtl/core/bdbd_pkg.sv -----
package bdbd_pkg;

  // Default number of scanned buttons.
  localparam int NUM_BUTTONS_DEF = 6;

  // Field widths of the input request.
  localparam int NOW_W    = 32;
  localparam int LEVELS_W = 6;
  localparam int POS_W    = 4;
  localparam int VBUS_W   = 2;

  // Field widths of the result.
  localparam int IDX_W = 3;
  localparam int SEL_W = 4;
  localparam int CMP_W = 16;

  // Configuration register widths.
  localparam int DEB_W      = 10;
  localparam int DIMMIN_W   = 8;
  localparam int PCT_W      = 7;
  localparam int PER_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Stream data widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  // Precomputed products: period times percent, and the idle threshold in ms.
  localparam int PROD_W   = 23;
  localparam int THRESH_W = 24;

  localparam int MS_PER_MIN = 60000;
  localparam int DIM_PCT    = 99;
  localparam int VBUS_USB   = 2;

  // Register reset values.
  localparam int DEBOUNCE_RST = 100;
  localparam int DIM_MIN_RST  = 5;
  localparam int PCT_RST      = 100;
  localparam int PERIOD_RST   = 65535;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_DIM_MIN  = 2'd1,
    CFG_BRIGHT   = 2'd2,
    CFG_PERIOD   = 2'd3
  } cfg_idx_e;

  // Configuration as seen by the poll logic.
  typedef struct packed {
    logic [DEB_W-1:0]    debounce_ms;
    logic [THRESH_W-1:0] dim_thresh_ms;
    logic [CMP_W-1:0]    bright_cmp;
    logic [CMP_W-1:0]    dim_cmp;
  } bl_cfg_t;

endpackage

// ----- rtl/core/bdbd_cfg.sv -----
module bdbd_cfg
  import bdbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output bl_cfg_t               cfg_o
);

  // floor(x / 100) as a multiply by ceil(2^30 / 100); exact for all x below 2^23.
  localparam int                RECIP_W     = 24;
  localparam int                RECIP_SHIFT = 30;
  localparam int                QUO_W       = 17;
  localparam logic [RECIP_W-1:0] RECIP_MUL  = 24'd10737419;

  localparam logic [PROD_W-1:0]   BRIGHT_PROD_RST = PROD_W'(PERIOD_RST * PCT_RST);
  localparam logic [PROD_W-1:0]   DIM_PROD_RST    = PROD_W'(PERIOD_RST * DIM_PCT);
  localparam logic [THRESH_W-1:0] THRESH_RST      = THRESH_W'(DIM_MIN_RST * MS_PER_MIN);

  function automatic logic [QUO_W-1:0] div100(input logic [PROD_W-1:0] x);
    logic [PROD_W+RECIP_W-1:0] p;
    p = (PROD_W+RECIP_W)'(x) * (PROD_W+RECIP_W)'(RECIP_MUL);
    return p[RECIP_SHIFT +: QUO_W];
  endfunction

  logic [DEB_W-1:0]    debounce_q, debounce_d;
  logic [PCT_W-1:0]    pct_q, pct_d;
  logic [PER_W-1:0]    period_q, period_d;
  logic [PROD_W-1:0]   bright_prod_q, bright_prod_d;
  logic [PROD_W-1:0]   dim_prod_q, dim_prod_d;
  logic [THRESH_W-1:0] thresh_q, thresh_d;
  logic [QUO_W-1:0]    bright_quo;
  logic [QUO_W-1:0]    dim_quo;

  // The products are formed at write time so that the poll path only divides.
  always_comb begin
    debounce_d    = debounce_q;
    pct_d         = pct_q;
    period_d      = period_q;
    bright_prod_d = bright_prod_q;
    dim_prod_d    = dim_prod_q;
    thresh_d      = thresh_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE: begin
          debounce_d = cfg_wdata_i[DEB_W-1:0];
        end
        CFG_DIM_MIN: begin
          thresh_d = THRESH_W'(cfg_wdata_i[DIMMIN_W-1:0]) * THRESH_W'(MS_PER_MIN);
        end
        CFG_BRIGHT: begin
          pct_d         = cfg_wdata_i[PCT_W-1:0];
          bright_prod_d = PROD_W'(period_q) * PROD_W'(cfg_wdata_i[PCT_W-1:0]);
        end
        CFG_PERIOD: begin
          period_d      = cfg_wdata_i[PER_W-1:0];
          bright_prod_d = PROD_W'(cfg_wdata_i[PER_W-1:0]) * PROD_W'(pct_q);
          dim_prod_d    = PROD_W'(cfg_wdata_i[PER_W-1:0]) * PROD_W'(DIM_PCT);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DEB_W'(DEBOUNCE_RST);
      pct_q         <= PCT_W'(PCT_RST);
      period_q      <= PER_W'(PERIOD_RST);
      bright_prod_q <= BRIGHT_PROD_RST;
      dim_prod_q    <= DIM_PROD_RST;
      thresh_q      <= THRESH_RST;
    end else begin
      debounce_q    <= debounce_d;
      pct_q         <= pct_d;
      period_q      <= period_d;
      bright_prod_q <= bright_prod_d;
      dim_prod_q    <= dim_prod_d;
      thresh_q      <= thresh_d;
    end
  end

  assign bright_quo = div100(bright_prod_q);
  assign dim_quo    = div100(dim_prod_q);

  // A brightness above one hundred percent can exceed the compare range.
  assign cfg_o.debounce_ms   = debounce_q;
  assign cfg_o.dim_thresh_ms = thresh_q;
  assign cfg_o.bright_cmp    = (bright_quo[QUO_W-1:CMP_W] != '0) ? '1 : bright_quo[CMP_W-1:0];
  assign cfg_o.dim_cmp       = dim_quo[CMP_W-1:0];

endmodule

// ----- rtl/core/button_debounce_backlight_dimmer_core.sv -----
// Button debounce, tool selector and backlight inactivity dimmer. Each input
// request is one poll: a millisecond timestamp, the active-low button levels,
// the selector position and the USB VBUS code. Every poll yields exactly one
// result: a debounced button event, a selection change, an optional backlight
// compare write and the dimmed state after the poll. The block takes one poll
// per clock cycle while the result side keeps up; a poll is held in the input
// register, and its result is then registered in the output register. Both
// registers hold a request while the downstream side stalls, so a new poll is
// still taken while a finished result waits. The compare values
// period*percent/100 and period*99/100 and the idle threshold in milliseconds
// are prepared when a register is written, so configuration writes take
// effect for the very next poll. Elapsed times are computed modulo 2^32. The
// display comes out of reset dimmed.
module button_debounce_backlight_dimmer_core
  import bdbd_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  // Poll requests.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: now_ms[31:0], button_levels[37:32],
  // selector_position[41:38], vbus_state[43:42], zero padding.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

  // Poll results.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0: button_event[0], button_index[3:1],
  // selection_changed[4], selection[8:5], backlight_write[9],
  // backlight_compare[25:10], display_dimmed[26], zero padding.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,

  // Register writes.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int BIDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int PAD_W  = OUT_TDATA_W - (3 + IDX_W + SEL_W + CMP_W + 1);

  typedef struct packed {
    logic [PAD_W-1:0] pad;
    logic             display_dimmed;
    logic [CMP_W-1:0] backlight_compare;
    logic             backlight_write;
    logic [SEL_W-1:0] selection;
    logic             selection_changed;
    logic [IDX_W-1:0] button_index;
    logic             button_event;
  } res_t;

  bl_cfg_t cfg;

  bdbd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake and pipeline control.
  logic accept;
  logic fire;
  logic in_vld_q, in_vld_d;
  logic out_vld_q, out_vld_d;

  // Input register, payload only.
  logic [NOW_W-1:0]    now_q;
  logic [LEVELS_W-1:0] levels_q;
  logic [POS_W-1:0]    pos_q;
  logic [VBUS_W-1:0]   vbus_q;

  // Poll state.
  logic              has_sel_q, has_sel_n;
  logic [SEL_W-1:0]  cur_sel_q, cur_sel_n;
  logic              lbv_q, lbv_n;
  logic [BIDX_W-1:0] lb_q, lb_n;
  logic [NOW_W-1:0]  pstart_q, pstart_n;
  logic              delivered_q, delivered_n;
  logic [NOW_W-1:0]  li_q, li_n;
  logic              dimmed_q, dimmed_n;

  res_t res_q, res_n;

  // Per-poll decode.
  logic [NUM_BUTTONS+LEVELS_W-1:0] lev_ext;
  logic              found;
  logic [BIDX_W-1:0] pidx;
  logic [SEL_W-1:0]  sel;
  logic              sel_hit;
  logic              same_btn;
  logic              held;
  logic              btn_new;
  logic              btn_fire;
  logic              btn_release;
  logic              usb;
  logic              idle_long;
  logic              dim_now;
  logic              any_int;
  logic              bright_wr;
  logic              ev;

  assign fire          = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | fire;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign in_vld_d      = accept | (in_vld_q & ~fire);
  assign out_vld_d     = fire | (out_vld_q & ~m_axis_tready);

  // Buttons above the six level bits read as zero, which is a press.
  assign lev_ext = {{NUM_BUTTONS{1'b0}}, levels_q};

  // Lowest-index pressed button wins.
  always_comb begin
    found = 1'b0;
    pidx  = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (!lev_ext[i]) begin
        found = 1'b1;
        pidx  = BIDX_W'(i);
      end
    end
  end

  assign sel     = pos_q - POS_W'(1);
  assign sel_hit = (pos_q != '0) && (!has_sel_q || (cur_sel_q != sel));

  // Buttons are scanned only once a selection exists, including this poll's.
  assign same_btn    = lbv_q && (lb_q == pidx);
  assign held        = (now_q - pstart_q) > NOW_W'(cfg.debounce_ms);
  assign btn_new     = has_sel_n & found & ~same_btn;
  assign btn_fire    = has_sel_n & found & same_btn & held & ~delivered_q;
  assign btn_release = has_sel_n & ~found;

  assign usb       = vbus_q >= VBUS_W'(VBUS_USB);
  assign idle_long = (now_q - li_q) > NOW_W'(cfg.dim_thresh_ms);

  // An interaction earlier in the same poll resets the idle time to zero, so
  // dimming only happens on a poll without selector or button activity.
  assign dim_now   = ~dimmed_q & ~usb & ~sel_hit & ~btn_fire & idle_long;
  assign any_int   = sel_hit | btn_fire | usb;
  assign bright_wr = dimmed_q & any_int;

  // The event is suppressed while dimmed, judged after any selector undim.
  assign ev = btn_fire & ~(dimmed_q & ~sel_hit);

  always_comb begin
    has_sel_n   = has_sel_q | sel_hit;
    cur_sel_n   = sel_hit ? sel : cur_sel_q;
    lbv_n       = lbv_q | btn_new;
    lb_n        = btn_new ? pidx : lb_q;
    pstart_n    = btn_new ? now_q : pstart_q;
    delivered_n = delivered_q;
    if (btn_new) begin
      delivered_n = 1'b0;
    end else if (btn_fire) begin
      delivered_n = 1'b1;
    end else if (btn_release) begin
      delivered_n = 1'b0;
    end
    li_n = any_int ? now_q : li_q;
    if (dim_now) begin
      dimmed_n = 1'b1;
    end else if (any_int) begin
      dimmed_n = 1'b0;
    end else begin
      dimmed_n = dimmed_q;
    end

    res_n                   = '0;
    res_n.button_event      = ev;
    res_n.button_index      = ev ? IDX_W'(pidx) : '0;
    res_n.selection_changed = sel_hit;
    res_n.selection         = cur_sel_n;
    res_n.backlight_write   = dim_now | bright_wr;
    if (dim_now) begin
      res_n.backlight_compare = cfg.dim_cmp;
    end else if (bright_wr) begin
      res_n.backlight_compare = cfg.bright_cmp;
    end
    res_n.display_dimmed = dimmed_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      has_sel_q   <= 1'b0;
      cur_sel_q   <= '0;
      lbv_q       <= 1'b0;
      lb_q        <= '0;
      pstart_q    <= '0;
      delivered_q <= 1'b0;
      li_q        <= '0;
      dimmed_q    <= 1'b1;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (fire) begin
        has_sel_q   <= has_sel_n;
        cur_sel_q   <= cur_sel_n;
        lbv_q       <= lbv_n;
        lb_q        <= lb_n;
        pstart_q    <= pstart_n;
        delivered_q <= delivered_n;
        li_q        <= li_n;
        dimmed_q    <= dimmed_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q    <= s_axis_tdata[0 +: NOW_W];
      levels_q <= s_axis_tdata[NOW_W +: LEVELS_W];
      pos_q    <= s_axis_tdata[NOW_W+LEVELS_W +: POS_W];
      vbus_q   <= s_axis_tdata[NOW_W+LEVELS_W+POS_W +: VBUS_W];
    end
    if (fire) begin
      res_q <= res_n;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;

`ifndef NO_ASSERTIONS
  // A delivered button event always leaves the display lit.
  a_ev_undimmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.button_event |-> !res_q.display_dimmed)
    else $error("button event reported with the display dimmed");

  // A selection change is an interaction and leaves the display lit.
  a_sel_undimmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.selection_changed |-> !res_q.display_dimmed)
    else $error("selection change reported with the display dimmed");

  // USB power keeps the display lit.
  a_usb_undim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && usb |=> !dimmed_q)
    else $error("display dimmed while on USB power");

  // A compare write goes with a change of the dimmed state, and only then.
  a_wr_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> res_q.backlight_write == (dimmed_q != $past(dimmed_q)))
    else $error("backlight write does not match a dimmed state change");

  // Without a write the compare field reads as zero.
  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.backlight_write |-> res_q.backlight_compare == '0)
    else $error("backlight compare nonzero without a write");
`endif

endmodule

// ----- tb/sv/button_debounce_backlight_dimmer_core_tb.sv -----
// Self-checking bench for the button debounce, selector and backlight dimmer
// core. Polls go in on the request stream, and one result per poll comes back.
// A behavioral model inside the bench tracks the selection, the debounce
// state and the dimmer state. For every accepted request it computes the
// result the core must return. Returned results are compared field by field,
// in order.
//
// The run has three parts:
//   - A short directed table right after reset, with the register defaults.
//     Its few rows whose outcome is obvious carry a typed-in result.
//   - Several register settings, including both extremes. Each gets a burst
//     of random polls.
//   - Random polls built as button holds, selector moves and clock advances,
//     with some noise mixed in.
// Both stream sides idle at random. The result side also holds off once for
// a long stretch, so that the core backs up into its request port.
module button_debounce_backlight_dimmer_core_tb;
  import bdbd_pkg::*;

  localparam int NUM_BTN      = NUM_BUTTONS_DEF;
  localparam int N_PHASES     = 6;
  localparam int PHASE_POLLS  = 163;
  localparam int SETTLE       = 6;
  localparam int LONG_HOLD    = 300;
  localparam int WATCHDOG     = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_N        = 23;

  // One poll as it is packed on the request stream; the lowest field is last.
  typedef struct packed {
    logic [VBUS_W-1:0]   vbus;
    logic [POS_W-1:0]    pos;
    logic [LEVELS_W-1:0] levels;
    logic [NOW_W-1:0]    now;
  } poll_t;

  // One result as it is packed on the result stream; the lowest field is last.
  typedef struct packed {
    logic             dimmed;
    logic [CMP_W-1:0] compare;
    logic             bl_write;
    logic [SEL_W-1:0] selection;
    logic             sel_changed;
    logic [IDX_W-1:0] btn_idx;
    logic             btn_event;
  } result_t;

  localparam int POLL_W = $bits(poll_t);
  localparam int RES_W  = $bits(result_t);

  typedef struct {
    poll_t   poll;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // Fields from bit 0: now_ms, button_levels, selector_position, vbus_state.
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // Fields from bit 0: button_event, button_index, selection_changed,
  // selection, backlight_write, backlight_compare, display_dimmed.
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  button_debounce_backlight_dimmer_core #(
    .NUM_BUTTONS(NUM_BTN)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Register copies held by the model.
  logic [DEB_W-1:0]    cfg_deb;
  logic [DIMMIN_W-1:0] cfg_dim_min;
  logic [PCT_W-1:0]    cfg_pct;
  logic [PER_W-1:0]    cfg_period;

  // Model state: selection, debounce tracker and dimmer.
  logic                sel_valid;
  logic [SEL_W-1:0]    sel_cur;
  logic                btn_valid;
  logic [IDX_W-1:0]    btn_last;
  logic [NOW_W-1:0]    hold_start;
  logic                hold_done;
  logic [NOW_W-1:0]    last_touch;
  logic                is_dim;

  result_t poll_results_q[$];

  int unsigned n_polls;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned n_events;
  int unsigned n_sel_changes;
  int unsigned n_bright_writes;
  int unsigned n_dim_writes;
  int unsigned idle_cycles;
  bit          tx_bursty;
  bit          rx_bursty;

  // Register settings per phase: both extremes, a saturating brightness,
  // one odd mix, and two random settings filled in at run time.
  int unsigned phase_deb    [N_PHASES] = '{0, 1000, 1, 37, 0, 0};
  int unsigned phase_dim    [N_PHASES] = '{0, 255, 1, 2, 0, 0};
  int unsigned phase_pct    [N_PHASES] = '{0, 100, 127, 50, 0, 0};
  int unsigned phase_period [N_PHASES] = '{0, 65535, 65535, 12345, 0, 0};

  // Directed rows. The poll is {vbus, position, levels, now}. The typed
  // result is {dimmed, compare, write, selection, changed, index, event}.
  // The rows run with the reset values: 100 ms debounce, 5 minutes,
  // full brightness and period 65535.
  dir_row_t dir_rows [DIR_N] = '{
    // Out of reset the display is dimmed and nothing is selected.
    '{'{2'd0, 4'd0, 6'h3F, 32'd0},      1'b1, '{1'b1, 16'd0, 1'b0, 4'd0, 1'b0, 3'd0, 1'b0}},
    // A press without a selection is ignored.
    '{'{2'd0, 4'd0, 6'h3E, 32'd10},     1'b0, '0},
    // The first selection wakes the display at full brightness.
    '{'{2'd0, 4'd1, 6'h3F, 32'd20},     1'b1, '{1'b0, 16'hFFFF, 1'b1, 4'd0, 1'b1, 3'd0, 1'b0}},
    // Hold button 0: start, exactly at the debounce time, one past it.
    '{'{2'd0, 4'd1, 6'h3E, 32'd30},     1'b0, '0},
    '{'{2'd0, 4'd1, 6'h3E, 32'd130},    1'b0, '0},
    '{'{2'd0, 4'd1, 6'h3E, 32'd131},    1'b0, '0},
    '{'{2'd0, 4'd1, 6'h3E, 32'd500},    1'b0, '0},
    // On release the button is remembered, so a new press fires at once.
    '{'{2'd0, 4'd1, 6'h3F, 32'd600},    1'b0, '0},
    '{'{2'd0, 4'd1, 6'h3E, 32'd610},    1'b0, '0},
    // The last button alone, on battery code 1.
    '{'{2'd1, 4'd1, 6'h1F, 32'd620},    1'b0, '0},
    '{'{2'd1, 4'd1, 6'h1F, 32'd800},    1'b0, '0},
    // A selector position above nine, then the top regular position.
    '{'{2'd0, 4'd15, 6'h1F, 32'd810},   1'b0, '0},
    '{'{2'd0, 4'd9, 6'h3F, 32'd820},    1'b0, '0},
    // USB power counts as interaction.
    '{'{2'd3, 4'd9, 6'h3F, 32'd830},    1'b0, '0},
    // One millisecond past five minutes on battery: dim to 99 percent.
    '{'{2'd0, 4'd9, 6'h3F, 32'd300831}, 1'b1, '{1'b1, 16'd64879, 1'b1, 4'd8, 1'b0, 3'd0, 1'b0}},
    // While dimmed a debounced press gives no event but wakes the display.
    '{'{2'd0, 4'd9, 6'h3D, 32'd300900}, 1'b0, '0},
    '{'{2'd0, 4'd9, 6'h3D, 32'd301100}, 1'b1, '{1'b0, 16'hFFFF, 1'b1, 4'd8, 1'b0, 3'd0, 1'b0}},
    // Time wraps across zero: the elapsed time is taken modulo 2^32.
    '{'{2'd2, 4'd9, 6'h3F, 32'hFFFF_FFF0}, 1'b0, '0},
    '{'{2'd0, 4'd0, 6'h3F, 32'h0000_0010}, 1'b0, '0},
    // All buttons pressed: button 0 wins.
    '{'{2'd1, 4'd0, 6'h00, 32'd20},     1'b0, '0},
    '{'{2'd1, 4'd0, 6'h3F, 32'd300021}, 1'b0, '0},
    // USB while dimmed wakes the display.
    '{'{2'd2, 4'd0, 6'h3F, 32'd300030}, 1'b0, '0},
    '{'{2'd0, 4'd0, 6'h2A, 32'd300040}, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Gap length before a request or a ready: mostly none, sometimes a few
  // cycles, rarely a long one. In busy stretches there is no gap at all.
  function automatic int unsigned idle_len(bit bursty);
    int unsigned r;
    if (!bursty) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Any interaction: note the time and wake the display at the bright level.
  task automatic note_touch(input logic [NOW_W-1:0] now, inout result_t r);
    logic [31:0] bright;
    last_touch = now;
    if (is_dim) begin
      bright = (32'(cfg_period) * 32'(cfg_pct)) / 32'd100;
      if (bright > 32'hFFFF) bright = 32'hFFFF;
      is_dim     = 1'b0;
      r.bl_write = 1'b1;
      r.compare  = bright[CMP_W-1:0];
    end
  endtask

  // Advances the model by one poll and returns the result it produces.
  task automatic poll_response(input poll_t p, output result_t r);
    logic [NOW_W-1:0] elapsed;
    logic [31:0]      dim_thresh;
    int               pick;
    r = '0;
    if (p.pos != '0) begin
      if (!sel_valid || sel_cur != p.pos - 4'd1) begin
        sel_cur       = p.pos - 4'd1;
        sel_valid     = 1'b1;
        r.sel_changed = 1'b1;
        note_touch(p.now, r);
      end
    end

    // Buttons are debounced only once a tool is selected.
    if (sel_valid) begin
      pick = -1;
      for (int i = NUM_BTN - 1; i >= 0; i--) begin
        if (!p.levels[i]) pick = i;
      end
      if (pick >= 0) begin
        elapsed = p.now - hold_start;
        if (!btn_valid || btn_last != pick[IDX_W-1:0]) begin
          btn_valid  = 1'b1;
          btn_last   = pick[IDX_W-1:0];
          hold_start = p.now;
          hold_done  = 1'b0;
        end else if (elapsed > 32'(cfg_deb) && !hold_done) begin
          if (!is_dim) begin
            r.btn_event = 1'b1;
            r.btn_idx   = pick[IDX_W-1:0];
          end
          note_touch(p.now, r);
          hold_done = 1'b1;
        end
      end else begin
        hold_done = 1'b0;
      end
    end

    // The dim check comes last; USB power keeps the display awake instead.
    elapsed    = p.now - last_touch;
    dim_thresh = 32'(cfg_dim_min) * MS_PER_MIN;
    if (!is_dim && p.vbus < VBUS_USB && elapsed > dim_thresh) begin
      is_dim     = 1'b1;
      r.bl_write = 1'b1;
      r.compare  = 16'((32'(cfg_period) * DIM_PCT) / 32'd100);
    end else if (p.vbus >= VBUS_USB) begin
      note_touch(p.now, r);
    end
    r.selection = sel_cur;
    r.dimmed    = is_dim;
  endtask

  // Offers one poll, holding it until it is taken, and then records what
  // must come back for it.
  task automatic send_poll(input poll_t p, input bit typed, input result_t typed_res);
    int unsigned gap;
    result_t     want;
    if ($urandom_range(0, 49) == 0) tx_bursty = !tx_bursty;
    gap = idle_len(tx_bursty);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - POLL_W){1'b0}}, p};
    do @(posedge clk_i); while (!s_axis_tready);
    poll_response(p, want);
    if (typed) want = typed_res;
    poll_results_q.push_back(want);
    n_polls++;
  endtask

  // Stops offering polls and waits until every result is back and the core
  // has settled.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (poll_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Register write. The model copy is updated at the same time; no poll is
  // in flight when this is called.
  task automatic set_reg(input cfg_idx_e idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_DEBOUNCE: cfg_deb     = val[DEB_W-1:0];
      CFG_DIM_MIN:  cfg_dim_min = val[DIMMIN_W-1:0];
      CFG_BRIGHT:   cfg_pct     = val[PCT_W-1:0];
      CFG_PERIOD:   cfg_period  = val[PER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (n_errors < MAX_REPORTS) begin
        $display("[%0t] result %0d: %s expected %0d, got %0d", $realtime, n_results,
                 name, want, got);
      end
      n_errors++;
    end
  endtask

  // Result side: random ready gaps, busy stretches, and one long hold-off
  // once a few hundred results have come back. The hold-off lets the core
  // fill up and stall its request port.
  initial begin
    int unsigned rx_gap;
    int unsigned hold_left;
    bit          hold_done_once;
    m_axis_tready  = 1'b0;
    rx_gap         = 0;
    hold_left      = 0;
    hold_done_once = 1'b0;
    rx_bursty      = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 149) == 0) rx_bursty = !rx_bursty;
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done_once && n_results >= 400) begin
        hold_done_once = 1'b1;
        hold_left      = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        m_axis_tready <= 1'b0;
        rx_gap--;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap = idle_len(rx_bursty);
      end
    end
  end

  // Result checker: each accepted result is matched against the oldest
  // outstanding expectation.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[RES_W-1:0];
      n_results++;
      if (got.btn_event) n_events++;
      if (got.sel_changed) n_sel_changes++;
      if (got.bl_write && got.dimmed) n_dim_writes++;
      if (got.bl_write && !got.dimmed) n_bright_writes++;
      if (poll_results_q.size() == 0) begin
        if (n_errors < MAX_REPORTS) begin
          $display("[%0t] result %0d arrived with no poll outstanding: %h", $realtime,
                   n_results, m_axis_tdata);
        end
        n_errors++;
      end else begin
        want = poll_results_q.pop_front();
        check_field("button_event", want.btn_event, got.btn_event);
        check_field("button_index", want.btn_idx, got.btn_idx);
        check_field("selection_changed", want.sel_changed, got.sel_changed);
        check_field("selection", want.selection, got.selection);
        check_field("backlight_write", want.bl_write, got.bl_write);
        check_field("backlight_compare", want.compare, got.compare);
        check_field("display_dimmed", want.dimmed, got.dimmed);
      end
    end
  end

  // Watchdog: a long run of cycles with no request and no result taken
  // means the core is stuck.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Timeout after %0d cycles without progress", WATCHDOG);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    poll_t            p;
    logic [NOW_W-1:0] t;
    logic [POS_W-1:0] cur_pos;
    logic [31:0]      th;
    int               held;
    int unsigned      hold_left;
    int unsigned      r;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DEBOUNCE;
    cfg_wdata_i   = '0;
    tx_bursty     = 1'b1;
    idle_cycles   = 0;
    n_polls = 0; n_results = 0; n_errors = 0;
    n_events = 0; n_sel_changes = 0; n_bright_writes = 0; n_dim_writes = 0;

    // Model state after reset: register defaults, nothing selected, dimmed.
    cfg_deb     = DEB_W'(DEBOUNCE_RST);
    cfg_dim_min = DIMMIN_W'(DIM_MIN_RST);
    cfg_pct     = PCT_W'(PCT_RST);
    cfg_period  = PER_W'(PERIOD_RST);
    sel_valid = 1'b0; sel_cur = '0; btn_valid = 1'b0; btn_last = '0;
    hold_start = '0; hold_done = 1'b0; last_touch = '0; is_dim = 1'b1;

    for (int k = 4; k < N_PHASES; k++) begin
      phase_deb[k]    = $urandom_range(0, 1000);
      phase_dim[k]    = $urandom_range(0, 3);
      phase_pct[k]    = $urandom_range(0, 127);
      phase_period[k] = $urandom_range(0, 65535);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_poll(dir_rows[i].poll, dir_rows[i].typed, dir_rows[i].res);

    t         = 32'd300040;
    cur_pos   = 4'd1;
    held      = -1;
    hold_left = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      set_reg(CFG_DEBOUNCE, phase_deb[ph]);
      set_reg(CFG_DIM_MIN, phase_dim[ph]);
      set_reg(CFG_BRIGHT, phase_pct[ph]);
      set_reg(CFG_PERIOD, phase_period[ph]);
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      th = 32'(cfg_dim_min) * MS_PER_MIN;

      for (int k = 0; k < PHASE_POLLS; k++) begin
        // Clock advance: mostly small steps around the debounce time,
        // sometimes beyond the idle threshold, rarely a jump anywhere.
        r = $urandom_range(0, 99);
        if (r < 40)      t = t + $urandom_range(0, 40);
        else if (r < 75) t = t + $urandom_range(0, 2 * cfg_deb + 2);
        else if (r < 90) t = t + cfg_deb + $urandom_range(0, 1);
        else if (r < 98) t = t + $urandom_range(th / 2, th * 2 + 2);
        else             t = $urandom;

        // Buttons: holds of a few polls on one button, some releases,
        // and some noise patterns.
        if (hold_left == 0) begin
          r         = $urandom_range(0, 99);
          held      = (r < 30) ? -1 : (r < 90) ? int'($urandom_range(0, NUM_BTN - 1)) : -2;
          hold_left = $urandom_range(1, 12);
        end
        hold_left--;
        if (held == -1) begin
          p.levels = '1;
        end else if (held == -2) begin
          p.levels = LEVELS_W'($urandom);
        end else begin
          p.levels = LEVELS_W'($urandom);
          for (int j = 0; j < held; j++) p.levels[j] = 1'b1;
          p.levels[held] = 1'b0;
        end

        // Selector: mostly steady, with moves, dropouts and odd positions.
        r = $urandom_range(0, 99);
        if (r < 88)      p.pos = cur_pos;
        else if (r < 94) begin cur_pos = POS_W'($urandom_range(1, 9)); p.pos = cur_pos; end
        else if (r < 97) p.pos = '0;
        else             begin cur_pos = POS_W'($urandom_range(10, 15)); p.pos = cur_pos; end

        p.vbus = ($urandom_range(0, 99) < 80) ? VBUS_W'($urandom_range(0, 1))
                                               : VBUS_W'($urandom_range(2, 3));
        p.now  = t;
        send_poll(p, 1'b0, '0);

        // Once mid-phase, stop sending until every result has come back.
        if (ph == 3 && k == 80) drain_results();
      end
    end
    drain_results();

    if (poll_results_q.size() != 0) begin
      $display("%0d results never arrived", poll_results_q.size());
      n_errors += poll_results_q.size();
    end
    $display("Covered %0d polls under %0d register settings; %0d results checked.",
             n_polls, N_PHASES + 1, n_results);
    $display("Seen: %0d button events, %0d selection changes, %0d bright and %0d dim writes.",
             n_events, n_sel_changes, n_bright_writes, n_dim_writes);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
